// File: src/rwhp_pkg.sv
// Shared types and constants for the RIFF/WAVE header parser.
package rwhp_pkg;

  localparam int unsigned TDATA_W = 128;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_CORE_BYTES = 32'd16;
  localparam logic [3:0]  FMT_LAST_IDX   = 4'd15;
  localparam logic [3:0]  WORD_LAST_IDX  = 4'd3;

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] DEPTH_8   = 16'd8;
  localparam logic [15:0] DEPTH_16  = 16'd16;
  localparam logic [15:0] DEPTH_24  = 16'd24;
  localparam logic [15:0] DEPTH_32  = 16'd32;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_REPORT  = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_TAG  = 3'd1;
  localparam logic [2:0] ERR_NO_FMT   = 3'd2;
  localparam logic [2:0] ERR_NO_DATA  = 3'd3;
  localparam logic [2:0] ERR_NOT_PCM  = 3'd4;
  localparam logic [2:0] ERR_DEPTH    = 3'd5;
  localparam logic [2:0] ERR_TRUNC    = 3'd6;

  typedef enum logic [12:0] {
    PH_RIFF   = 13'b0_0000_0000_0001,
    PH_RSIZE  = 13'b0_0000_0000_0010,
    PH_WAVE   = 13'b0_0000_0000_0100,
    PH_C1ID   = 13'b0_0000_0000_1000,
    PH_C1SIZE = 13'b0_0000_0001_0000,
    PH_C1SKIP = 13'b0_0000_0010_0000,
    PH_FIELDS = 13'b0_0000_0100_0000,
    PH_EXTRA  = 13'b0_0000_1000_0000,
    PH_C2ID   = 13'b0_0001_0000_0000,
    PH_C2SIZE = 13'b0_0010_0000_0000,
    PH_C2SKIP = 13'b0_0100_0000_0000,
    PH_DATA   = 13'b0_1000_0000_0000,
    PH_HALT   = 13'b1_0000_0000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [15:0] sample_bits;
    logic [15:0] format_code;
    logic [31:0] payload_size;
    logic [2:0]  error_code;
  } result_t;

endpackage

// File: src/rwhp_in_reg.sv
// Input register stage: holds one accepted byte until the parser core takes it.
module rwhp_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rwhp_pkg::in_item_t in_item,
  input  logic              take,
  output logic              item_valid,
  output rwhp_pkg::in_item_t item
);

  logic               valid_r;
  logic               valid_nxt;
  rwhp_pkg::in_item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// File: src/rwhp_core.sv
// Parser core: header state machine and field capture, one byte per transaction.
module rwhp_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  rwhp_pkg::in_item_t item,
  input  logic               res_ready,
  output logic               take,
  output logic               res_valid,
  output rwhp_pkg::result_t  res
);

  rwhp_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  fbc_r, fbc_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [15:0] fmt_r, fmt_nxt;
  logic [31:0] data_r, data_nxt;
  logic        riff_ok_r, riff_ok_nxt;

  logic [7:0]  b;
  logic        last_in;
  logic [3:0]  fbc_inc;
  logic        word_done;
  logic [31:0] tag_in;
  logic [31:0] size_in;
  logic [31:0] skip_dec;
  logic [31:0] data_dec;
  logic        depth_ok;
  logic        hit;
  logic [2:0]  err;
  logic [2:0]  end_code;
  rwhp_pkg::result_t res_c;

  assign take      = item_valid && res_ready;
  assign b         = item.in_byte;
  assign last_in   = item.stream_end;
  assign fbc_inc   = fbc_r + 4'd1;
  assign word_done = (fbc_r >= rwhp_pkg::WORD_LAST_IDX);
  assign tag_in    = {b, tag_r[31:8]};
  assign size_in   = {b, size_r[31:8]};
  assign skip_dec  = skip_r - 32'd1;
  assign data_dec  = data_r - 32'd1;
  assign depth_ok  = (bits_r == rwhp_pkg::DEPTH_8) || (bits_r == rwhp_pkg::DEPTH_16) ||
                     (bits_r == rwhp_pkg::DEPTH_24) || (bits_r == rwhp_pkg::DEPTH_32);

  always_comb begin
    phase_nxt   = phase_r;
    fbc_nxt     = fbc_r;
    tag_nxt     = tag_r;
    size_nxt    = size_r;
    skip_nxt    = skip_r;
    chan_nxt    = chan_r;
    rate_nxt    = rate_r;
    bits_nxt    = bits_r;
    fmt_nxt     = fmt_r;
    data_nxt    = data_r;
    riff_ok_nxt = riff_ok_r;
    hit         = 1'b0;
    err         = rwhp_pkg::ERR_NONE;
    end_code    = rwhp_pkg::ERR_NONE;
    res_c       = '0;

    unique case (phase_r)
      rwhp_pkg::PH_RIFF: begin
        tag_nxt = tag_in;
        fbc_nxt = word_done ? 4'd0 : fbc_inc;
        if (word_done) begin
          riff_ok_nxt = (tag_in == rwhp_pkg::TAG_RIFF);
          phase_nxt   = rwhp_pkg::PH_RSIZE;
        end
      end
      rwhp_pkg::PH_RSIZE: begin
        size_nxt = size_in;
        fbc_nxt  = word_done ? 4'd0 : fbc_inc;
        if (word_done) begin
          phase_nxt = rwhp_pkg::PH_WAVE;
        end
      end
      rwhp_pkg::PH_WAVE: begin
        tag_nxt = tag_in;
        fbc_nxt = word_done ? 4'd0 : fbc_inc;
        if (word_done) begin
          if (!riff_ok_r || tag_in != rwhp_pkg::TAG_WAVE) begin
            hit = 1'b1;
            err = rwhp_pkg::ERR_BAD_TAG;
          end else begin
            phase_nxt = rwhp_pkg::PH_C1ID;
          end
        end
      end
      rwhp_pkg::PH_C1ID: begin
        tag_nxt = tag_in;
        fbc_nxt = word_done ? 4'd0 : fbc_inc;
        if (word_done) begin
          phase_nxt = rwhp_pkg::PH_C1SIZE;
        end
      end
      rwhp_pkg::PH_C1SIZE: begin
        size_nxt = size_in;
        fbc_nxt  = word_done ? 4'd0 : fbc_inc;
        if (word_done) begin
          if (tag_r == rwhp_pkg::TAG_FMT) begin
            skip_nxt  = (size_in > rwhp_pkg::FMT_CORE_BYTES) ?
                        size_in - rwhp_pkg::FMT_CORE_BYTES : 32'd0;
            phase_nxt = rwhp_pkg::PH_FIELDS;
          end else begin
            skip_nxt  = size_in;
            phase_nxt = (size_in != 32'd0) ? rwhp_pkg::PH_C1SKIP : rwhp_pkg::PH_C1ID;
          end
        end
      end
      rwhp_pkg::PH_C1SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == 32'd0) begin
          phase_nxt = rwhp_pkg::PH_C1ID;
        end
      end
      rwhp_pkg::PH_FIELDS: begin
        case (fbc_r)
          4'd0:    fmt_nxt[7:0]    = b;
          4'd1:    fmt_nxt[15:8]   = b;
          4'd2:    chan_nxt[7:0]   = b;
          4'd3:    chan_nxt[15:8]  = b;
          4'd4:    rate_nxt[7:0]   = b;
          4'd5:    rate_nxt[15:8]  = b;
          4'd6:    rate_nxt[23:16] = b;
          4'd7:    rate_nxt[31:24] = b;
          4'd14:   bits_nxt[7:0]   = b;
          4'd15:   bits_nxt[15:8]  = b;
          default: ;
        endcase
        fbc_nxt = fbc_inc;
        if (fbc_r == rwhp_pkg::FMT_LAST_IDX) begin
          fbc_nxt   = 4'd0;
          phase_nxt = (skip_r != 32'd0) ? rwhp_pkg::PH_EXTRA : rwhp_pkg::PH_C2ID;
        end
      end
      rwhp_pkg::PH_EXTRA: begin
        skip_nxt = skip_dec;
        if (skip_dec == 32'd0) begin
          phase_nxt = rwhp_pkg::PH_C2ID;
        end
      end
      rwhp_pkg::PH_C2ID: begin
        tag_nxt = tag_in;
        fbc_nxt = word_done ? 4'd0 : fbc_inc;
        if (word_done) begin
          phase_nxt = rwhp_pkg::PH_C2SIZE;
        end
      end
      rwhp_pkg::PH_C2SIZE: begin
        size_nxt = size_in;
        fbc_nxt  = word_done ? 4'd0 : fbc_inc;
        if (word_done) begin
          if (tag_r != rwhp_pkg::TAG_DATA) begin
            skip_nxt  = size_in;
            phase_nxt = (size_in != 32'd0) ? rwhp_pkg::PH_C2SKIP : rwhp_pkg::PH_C2ID;
          end else if (fmt_r != rwhp_pkg::FMT_PCM) begin
            hit = 1'b1;
            err = rwhp_pkg::ERR_NOT_PCM;
          end else if (!depth_ok) begin
            hit = 1'b1;
            err = rwhp_pkg::ERR_DEPTH;
          end else if (last_in && size_in != 32'd0) begin
            hit = 1'b1;
            err = rwhp_pkg::ERR_TRUNC;
          end else begin
            hit                 = 1'b1;
            data_nxt            = size_in;
            res_c.kind          = rwhp_pkg::KIND_REPORT;
            res_c.channel_count = chan_r;
            res_c.rate_hz       = rate_r;
            res_c.sample_bits   = bits_r;
            res_c.format_code   = fmt_r;
            res_c.payload_size  = size_in;
            phase_nxt = (size_in != 32'd0) ? rwhp_pkg::PH_DATA : rwhp_pkg::PH_HALT;
          end
        end
      end
      rwhp_pkg::PH_C2SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == 32'd0) begin
          phase_nxt = rwhp_pkg::PH_C2ID;
        end
      end
      rwhp_pkg::PH_DATA: begin
        data_nxt = data_dec;
        hit      = 1'b1;
        if (data_dec == 32'd0) begin
          res_c.kind         = rwhp_pkg::KIND_PAYLOAD;
          res_c.payload_byte = b;
          res_c.payload_last = 1'b1;
          phase_nxt          = rwhp_pkg::PH_HALT;
        end else if (last_in) begin
          err = rwhp_pkg::ERR_TRUNC;
        end else begin
          res_c.kind         = rwhp_pkg::KIND_PAYLOAD;
          res_c.payload_byte = b;
        end
      end
      rwhp_pkg::PH_HALT: ;
      default: phase_nxt = rwhp_pkg::PH_HALT;
    endcase

    if (last_in && !hit) begin
      unique case (phase_nxt) inside
        rwhp_pkg::PH_RIFF, rwhp_pkg::PH_RSIZE, rwhp_pkg::PH_WAVE, rwhp_pkg::PH_DATA:
          end_code = rwhp_pkg::ERR_TRUNC;
        rwhp_pkg::PH_C1ID, rwhp_pkg::PH_C1SKIP:
          end_code = rwhp_pkg::ERR_NO_FMT;
        rwhp_pkg::PH_C1SIZE:
          end_code = (tag_nxt == rwhp_pkg::TAG_FMT) ? rwhp_pkg::ERR_NO_DATA :
                                                     rwhp_pkg::ERR_NO_FMT;
        rwhp_pkg::PH_HALT:
          end_code = rwhp_pkg::ERR_NONE;
        default:
          end_code = rwhp_pkg::ERR_NO_DATA;
      endcase
      if (end_code != rwhp_pkg::ERR_NONE) begin
        hit = 1'b1;
        err = end_code;
      end
    end

    if (err != rwhp_pkg::ERR_NONE) begin
      res_c            = '0;
      res_c.kind       = rwhp_pkg::KIND_ERROR;
      res_c.error_code = err;
      phase_nxt        = rwhp_pkg::PH_HALT;
    end

    if (last_in) begin
      phase_nxt = rwhp_pkg::PH_RIFF;
      fbc_nxt   = 4'd0;
    end
  end

  assign res_valid = take && hit;
  assign res       = res_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rwhp_pkg::PH_RIFF;
      fbc_r   <= 4'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      fbc_r   <= fbc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tag_r     <= tag_nxt;
      size_r    <= size_nxt;
      skip_r    <= skip_nxt;
      chan_r    <= chan_nxt;
      rate_r    <= rate_nxt;
      bits_r    <= bits_nxt;
      fmt_r     <= fmt_nxt;
      data_r    <= data_nxt;
      riff_ok_r <= riff_ok_nxt;
    end
  end

endmodule

// File: src/rwhp_out_reg.sv
// Result register: holds one finished result until the receiver takes it.
module rwhp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  rwhp_pkg::result_t res,
  output logic              res_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rwhp_pkg::result_t out_res
);

  logic              valid_r;
  logic              valid_nxt;
  rwhp_pkg::result_t res_r;

  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (res_ready) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// File: src/riff_wave_header_parser_unit.sv
// Top level of the RIFF/WAVE PCM header parser.
// Usage:
//   The input stream carries a WAV file one byte per transaction on in_tdata,
//   with in_tlast high on the file's final byte. The result stream carries at
//   most one transaction per input byte: a format report once the data chunk
//   header is complete, then the payload bytes (out_tlast on the final one),
//   and at most one error per file, which ends its results. out_tuser gives
//   the kind of each transaction. Throughput is one byte per cycle: the block
//   takes a new byte every cycle while results drain. An accepted byte is
//   registered in the input register; the single-pass state machine update
//   is combinational and writes its result into the result register, which
//   drives out_tvalid.
//   After an error the parser drops bytes until in_tlast, and every in_tlast
//   byte returns it to the start of a new file.
//   Reset clears the phase and the field byte counter; no clearing pass is needed.
//   When the receiver holds out_tready low, the result register holds its
//   transaction, one more byte is taken into the input register, and then
//   in_tready falls until the result is taken.
module riff_wave_header_parser_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,  // [7:0] in_byte
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] payload_byte, [23:8] channel_count, [55:24] rate_hz, [71:56] sample_bits,
  // [87:72] format_code, [119:88] payload_size, [122:120] error_code, [127:123] zero
  output logic [rwhp_pkg::TDATA_W-1:0]  out_tdata,
  output logic                          out_tlast,
  output logic [1:0]                    out_tuser  // [1:0] kind
);

  rwhp_pkg::in_item_t in_item;
  rwhp_pkg::in_item_t item;
  rwhp_pkg::result_t  res;
  rwhp_pkg::result_t  out_res;
  logic               item_valid;
  logic               take;
  logic               res_valid;
  logic               res_ready;

  assign in_item.in_byte    = in_tdata;
  assign in_item.stream_end = in_tlast;

  rwhp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  rwhp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .res_ready  (res_ready),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  rwhp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {5'd0, out_res.error_code, out_res.payload_size, out_res.format_code,
                      out_res.sample_bits, out_res.rate_hz, out_res.channel_count,
                      out_res.payload_byte};
  assign out_tlast = out_res.payload_last;
  assign out_tuser = out_res.kind;

  a_last_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == rwhp_pkg::KIND_PAYLOAD)
    else $error("out_tlast on a non-payload transaction");

  a_error_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == rwhp_pkg::KIND_ERROR |-> out_res.error_code != rwhp_pkg::ERR_NONE)
    else $error("error transaction without an error code");

  a_no_code_otherwise: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != rwhp_pkg::KIND_ERROR |-> out_res.error_code == rwhp_pkg::ERR_NONE)
    else $error("error code on a non-error transaction");

  a_kind_defined: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != rwhp_pkg::KIND_UNUSED)
    else $error("undefined result kind");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> item_valid && out_tvalid && !out_tready)
    else $error("input stalled while a stage is free");

endmodule

// File: verif/wav_result_checker.sv
// Result checker for the RIFF/WAVE header parser: tracks parser state and compares every result.
module wav_result_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [7:0]                   in_tdata,
  input  logic                         in_tlast,
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [rwhp_pkg::TDATA_W-1:0] out_tdata,
  input  logic                         out_tlast,
  input  logic [1:0]                   out_tuser,
  output int                           fail_count,
  output int                           pending,
  output int                           reports_seen,
  output int                           errors_seen,
  output int                           payloads_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  rwhp_pkg::phase_t parse_phase;
  logic [4:0]       word_bytes;
  logic [31:0]      tag_word;
  logic [31:0]      size_word;
  logic [31:0]      skip_left;
  logic [15:0]      chan_hold;
  logic [31:0]      rate_hold;
  logic [15:0]      depth_hold;
  logic [15:0]      fmt_tag;
  logic [31:0]      data_left;
  logic             riff_seen_ok;

  rwhp_pkg::result_t step_out;
  bit                step_has;
  rwhp_pkg::result_t awaited_results[$];

  function automatic void restart_parser();
    parse_phase  = rwhp_pkg::PH_RIFF;
    word_bytes   = '0;
    tag_word     = '0;
    size_word    = '0;
    skip_left    = '0;
    chan_hold    = '0;
    rate_hold    = '0;
    depth_hold   = '0;
    fmt_tag      = '0;
    data_left    = '0;
    riff_seen_ok = 1'b0;
  endfunction

  function automatic bit count_word_byte();
    word_bytes = word_bytes + 5'd1;
    if (word_bytes >= 5'd4) begin
      word_bytes = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void emit_error(logic [2:0] code);
    step_out            = '0;
    step_out.kind       = rwhp_pkg::KIND_ERROR;
    step_out.error_code = code;
    step_has            = 1'b1;
    parse_phase         = rwhp_pkg::PH_HALT;
  endfunction

  function automatic void emit_payload(logic [7:0] b, logic is_last);
    step_out              = '0;
    step_out.kind         = rwhp_pkg::KIND_PAYLOAD;
    step_out.payload_byte = b;
    step_out.payload_last = is_last;
    step_has              = 1'b1;
  endfunction

  function automatic logic [2:0] early_end_code();
    case (parse_phase) inside
      rwhp_pkg::PH_RIFF, rwhp_pkg::PH_RSIZE, rwhp_pkg::PH_WAVE, rwhp_pkg::PH_DATA:
        return rwhp_pkg::ERR_TRUNC;
      rwhp_pkg::PH_C1ID, rwhp_pkg::PH_C1SKIP:
        return rwhp_pkg::ERR_NO_FMT;
      rwhp_pkg::PH_C1SIZE:
        return (tag_word == rwhp_pkg::TAG_FMT) ? rwhp_pkg::ERR_NO_DATA : rwhp_pkg::ERR_NO_FMT;
      rwhp_pkg::PH_HALT:
        return rwhp_pkg::ERR_NONE;
      default:
        return rwhp_pkg::ERR_NO_DATA;
    endcase
  endfunction

  function automatic void advance_parser(logic [7:0] b, logic is_end);
    int          i;
    logic [2:0]  code;
    step_out = '0;
    step_has = 1'b0;
    case (parse_phase)
      rwhp_pkg::PH_RIFF: begin
        tag_word = {b, tag_word[31:8]};
        if (count_word_byte()) begin
          riff_seen_ok = (tag_word == rwhp_pkg::TAG_RIFF);
          parse_phase  = rwhp_pkg::PH_RSIZE;
        end
      end
      rwhp_pkg::PH_RSIZE: begin
        size_word = {b, size_word[31:8]};
        if (count_word_byte()) parse_phase = rwhp_pkg::PH_WAVE;
      end
      rwhp_pkg::PH_WAVE: begin
        tag_word = {b, tag_word[31:8]};
        if (count_word_byte()) begin
          if (!riff_seen_ok || tag_word != rwhp_pkg::TAG_WAVE) emit_error(rwhp_pkg::ERR_BAD_TAG);
          else parse_phase = rwhp_pkg::PH_C1ID;
        end
      end
      rwhp_pkg::PH_C1ID: begin
        tag_word = {b, tag_word[31:8]};
        if (count_word_byte()) parse_phase = rwhp_pkg::PH_C1SIZE;
      end
      rwhp_pkg::PH_C1SIZE: begin
        size_word = {b, size_word[31:8]};
        if (count_word_byte()) begin
          if (tag_word == rwhp_pkg::TAG_FMT) begin
            skip_left   = (size_word > rwhp_pkg::FMT_CORE_BYTES) ?
                          size_word - rwhp_pkg::FMT_CORE_BYTES : '0;
            fmt_tag     = '0;
            chan_hold   = '0;
            rate_hold   = '0;
            depth_hold  = '0;
            parse_phase = rwhp_pkg::PH_FIELDS;
          end else begin
            skip_left = size_word;
            if (skip_left != 0) parse_phase = rwhp_pkg::PH_C1SKIP;
            else parse_phase = rwhp_pkg::PH_C1ID;
          end
        end
      end
      rwhp_pkg::PH_C1SKIP: begin
        skip_left = skip_left - 1;
        if (skip_left == 0) parse_phase = rwhp_pkg::PH_C1ID;
      end
      rwhp_pkg::PH_FIELDS: begin
        i = int'(word_bytes);
        if (i < 2) fmt_tag[8*i +: 8] = b;
        else if (i < 4) chan_hold[8*(i-2) +: 8] = b;
        else if (i < 8) rate_hold[8*(i-4) +: 8] = b;
        else if (i >= 14) depth_hold[8*(i-14) +: 8] = b;
        word_bytes = word_bytes + 5'd1;
        if (word_bytes >= 5'd16) begin
          word_bytes = '0;
          if (skip_left != 0) parse_phase = rwhp_pkg::PH_EXTRA;
          else parse_phase = rwhp_pkg::PH_C2ID;
        end
      end
      rwhp_pkg::PH_EXTRA: begin
        skip_left = skip_left - 1;
        if (skip_left == 0) parse_phase = rwhp_pkg::PH_C2ID;
      end
      rwhp_pkg::PH_C2ID: begin
        tag_word = {b, tag_word[31:8]};
        if (count_word_byte()) parse_phase = rwhp_pkg::PH_C2SIZE;
      end
      rwhp_pkg::PH_C2SIZE: begin
        size_word = {b, size_word[31:8]};
        if (count_word_byte()) begin
          if (tag_word != rwhp_pkg::TAG_DATA) begin
            skip_left = size_word;
            if (skip_left != 0) parse_phase = rwhp_pkg::PH_C2SKIP;
            else parse_phase = rwhp_pkg::PH_C2ID;
          end else if (fmt_tag != rwhp_pkg::FMT_PCM) begin
            emit_error(rwhp_pkg::ERR_NOT_PCM);
          end else if (depth_hold != rwhp_pkg::DEPTH_8 && depth_hold != rwhp_pkg::DEPTH_16 &&
                       depth_hold != rwhp_pkg::DEPTH_24 && depth_hold != rwhp_pkg::DEPTH_32) begin
            emit_error(rwhp_pkg::ERR_DEPTH);
          end else if (is_end && size_word != 0) begin
            emit_error(rwhp_pkg::ERR_TRUNC);
          end else begin
            data_left              = size_word;
            step_out               = '0;
            step_out.kind          = rwhp_pkg::KIND_REPORT;
            step_out.channel_count = chan_hold;
            step_out.rate_hz       = rate_hold;
            step_out.sample_bits   = depth_hold;
            step_out.format_code   = fmt_tag;
            step_out.payload_size  = data_left;
            step_has               = 1'b1;
            if (data_left != 0) parse_phase = rwhp_pkg::PH_DATA;
            else parse_phase = rwhp_pkg::PH_HALT;
          end
        end
      end
      rwhp_pkg::PH_C2SKIP: begin
        skip_left = skip_left - 1;
        if (skip_left == 0) parse_phase = rwhp_pkg::PH_C2ID;
      end
      rwhp_pkg::PH_DATA: begin
        data_left = data_left - 1;
        if (data_left == 0) begin
          emit_payload(b, 1'b1);
          parse_phase = rwhp_pkg::PH_HALT;
        end else if (is_end) begin
          emit_error(rwhp_pkg::ERR_TRUNC);
        end else begin
          emit_payload(b, 1'b0);
        end
      end
      default: parse_phase = rwhp_pkg::PH_HALT;
    endcase
    if (is_end) begin
      if (!step_has) begin
        code = early_end_code();
        if (code != rwhp_pkg::ERR_NONE) emit_error(code);
      end
      restart_parser();
    end
    if (step_has) awaited_results.push_back(step_out);
  endfunction

  function automatic void check_field(string label, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (fail_count < 50)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    rwhp_pkg::result_t want;
    if (!rst_n) begin
      restart_parser();
      awaited_results.delete();
      fail_count    = 0;
      pending       = 0;
      reports_seen  = 0;
      errors_seen   = 0;
      payloads_seen = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          if (fail_count < 50)
            $display("%0t ns: unexpected result, expected none, actual kind %0d data %h",
                     $time, out_tuser, out_tdata);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_tuser));
          check_field("payload_byte", 32'(want.payload_byte), 32'(out_tdata[7:0]));
          check_field("payload_last", 32'(want.payload_last), 32'(out_tlast));
          check_field("channel_count", 32'(want.channel_count), 32'(out_tdata[23:8]));
          check_field("rate_hz", want.rate_hz, out_tdata[55:24]);
          check_field("sample_bits", 32'(want.sample_bits), 32'(out_tdata[71:56]));
          check_field("format_code", 32'(want.format_code), 32'(out_tdata[87:72]));
          check_field("payload_size", want.payload_size, out_tdata[119:88]);
          check_field("error_code", 32'(want.error_code), 32'(out_tdata[122:120]));
          check_field("padding", 32'd0, 32'(out_tdata[127:123]));
          if (want.kind == rwhp_pkg::KIND_REPORT) reports_seen++;
          else if (want.kind == rwhp_pkg::KIND_ERROR) errors_seen++;
          else payloads_seen++;
        end
      end
      if (in_tvalid && in_tready) advance_parser(in_tdata, in_tlast);
      pending = awaited_results.size();
    end
  end

endmodule

// File: verif/tb_riff_wave_header_parser_unit.sv
// Testbench top for the RIFF/WAVE header parser: builds WAV byte streams and drives both channels.
module tb_riff_wave_header_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic        riff_bad;
    logic        wave_bad;
    logic        no_fmt;
    logic        no_data;
    logic [1:0]  pre_junk;
    logic [1:0]  mid_junk;
    logic [31:0] fmt_size;
    logic [15:0] fmt_code;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] chunk_bytes;
    logic [7:0]  payload_sent;
    logic [7:0]  cut_len;
  } wav_plan_t;

  logic                         clk;
  logic                         rst_n      = 1'b0;
  logic                         in_tvalid  = 1'b0;
  logic                         in_tready;
  logic [7:0]                   in_tdata   = '0;
  logic                         in_tlast   = 1'b0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [rwhp_pkg::TDATA_W-1:0] out_tdata;
  logic                         out_tlast;
  logic [1:0]                   out_tuser;

  int fail_count;
  int pending;
  int reports_seen;
  int errors_seen;
  int payloads_seen;

  logic [7:0] wav_image[$];
  logic [8:0] byte_stream[$];
  int         file_count  = 0;
  int         cycle_count = 0;
  int         stall_left  = 0;
  int         quiet_left  = 0;
  bit         calm        = 1'b0;

  riff_wave_header_parser_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  wav_result_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .pending       (pending),
    .reports_seen  (reports_seen),
    .errors_seen   (errors_seen),
    .payloads_seen (payloads_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
      quiet_left = 0;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (quiet_left != 0) begin
      out_tready <= 1'b1;
      quiet_left--;
    end else if ($urandom_range(0, 1) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(1, 16) - 1;
    end else begin
      out_tready <= 1'b1;
      quiet_left = $urandom_range(1, 48) - 1;
    end
  end

  task automatic put_word(input logic [31:0] w);
    wav_image.push_back(w[7:0]);
    wav_image.push_back(w[15:8]);
    wav_image.push_back(w[23:16]);
    wav_image.push_back(w[31:24]);
  endtask

  task automatic put_half(input logic [15:0] h);
    wav_image.push_back(h[7:0]);
    wav_image.push_back(h[15:8]);
  endtask

  task automatic put_junk(input bit before_fmt);
    logic [31:0] size;
    int          pick;
    pick = $urandom_range(0, 3);
    if (pick == 0) put_word(before_fmt ? rwhp_pkg::TAG_DATA : rwhp_pkg::TAG_FMT);
    else if (pick == 1) put_word(rwhp_pkg::TAG_RIFF);
    else put_word($urandom);
    if ($urandom_range(0, 9) == 0) size = $urandom | 32'h100;
    else size = $urandom_range(0, 5);
    put_word(size);
    repeat ((size > 5) ? 5 : size) wav_image.push_back(8'($urandom));
  endtask

  task automatic build_wav(input wav_plan_t p);
    int n;
    int k;
    wav_image.delete();
    put_word(p.riff_bad ? (rwhp_pkg::TAG_RIFF ^ (32'd1 << $urandom_range(0, 31))) :
                          rwhp_pkg::TAG_RIFF);
    put_word($urandom);
    put_word(p.wave_bad ? (rwhp_pkg::TAG_WAVE ^ (32'd1 << $urandom_range(0, 31))) :
                          rwhp_pkg::TAG_WAVE);
    repeat (p.pre_junk) put_junk(1'b1);
    if (!p.no_fmt) begin
      put_word(rwhp_pkg::TAG_FMT);
      put_word(p.fmt_size);
      put_half(p.fmt_code);
      put_half(p.chans);
      put_word(p.rate);
      put_word($urandom);
      put_half(16'($urandom));
      put_half(p.bits);
      if (p.fmt_size > rwhp_pkg::FMT_CORE_BYTES)
        repeat (p.fmt_size - rwhp_pkg::FMT_CORE_BYTES) wav_image.push_back(8'($urandom));
    end
    repeat (p.mid_junk) put_junk(1'b0);
    if (!p.no_data) begin
      put_word(rwhp_pkg::TAG_DATA);
      put_word(p.chunk_bytes);
      repeat (p.payload_sent) wav_image.push_back(8'($urandom));
    end
    n = wav_image.size();
    if (p.cut_len != 0 && p.cut_len < n) n = p.cut_len;
    for (k = 0; k < n; k++) byte_stream.push_back({k == n - 1, wav_image[k]});
    file_count++;
  endtask

  task automatic build_noise();
    int n;
    int k;
    n = $urandom_range(1, 20);
    for (k = 0; k < n; k++) byte_stream.push_back({k == n - 1, 8'($urandom)});
    file_count++;
  endtask

  function automatic wav_plan_t plain_plan();
    wav_plan_t p;
    p              = '0;
    p.fmt_size     = rwhp_pkg::FMT_CORE_BYTES;
    p.fmt_code     = rwhp_pkg::FMT_PCM;
    p.chans        = 16'd2;
    p.rate         = 32'd44100;
    p.bits         = rwhp_pkg::DEPTH_16;
    p.chunk_bytes  = 32'd2;
    p.payload_sent = 8'd2;
    return p;
  endfunction

  function automatic wav_plan_t random_plan();
    wav_plan_t p;
    int        r;
    p          = plain_plan();
    p.riff_bad = ($urandom_range(0, 24) == 0);
    p.wave_bad = ($urandom_range(0, 24) == 0);
    p.no_fmt   = ($urandom_range(0, 24) == 0);
    p.no_data  = ($urandom_range(0, 24) == 0);
    p.pre_junk = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 2)) : 2'd0;
    p.mid_junk = 2'($urandom_range(0, 2));
    r = $urandom_range(0, 7);
    if (r == 0) p.fmt_size = $urandom_range(0, 15);
    else if (r == 1) p.fmt_size = $urandom_range(17, 22);
    p.fmt_code = ($urandom_range(0, 11) == 0) ? 16'($urandom) : rwhp_pkg::FMT_PCM;
    p.chans    = 16'($urandom);
    p.rate     = $urandom;
    r = $urandom_range(0, 8);
    case (r % 4)
      0: p.bits = rwhp_pkg::DEPTH_8;
      1: p.bits = rwhp_pkg::DEPTH_16;
      2: p.bits = rwhp_pkg::DEPTH_24;
      default: p.bits = rwhp_pkg::DEPTH_32;
    endcase
    if (r == 8) p.bits = 16'($urandom);
    p.payload_sent = 8'($urandom_range(0, 12));
    r = $urandom_range(0, 15);
    if (r == 0) p.chunk_bytes = 32'(p.payload_sent) + $urandom_range(1, 3);
    else if (r == 1) p.chunk_bytes = $urandom_range(0, p.payload_sent);
    else if (r == 2) p.chunk_bytes = $urandom;
    else p.chunk_bytes = 32'(p.payload_sent);
    p.cut_len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 100)) : 8'd0;
    return p;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    bit took;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= is_last;
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
  endtask

  initial begin : stimulus
    wav_plan_t p;
    int        directed_bytes;
    int        idx;

    // truncated inside the RIFF header, including a one-byte file
    p = plain_plan(); p.cut_len = 8'd3; build_wav(p);
    p = plain_plan(); p.cut_len = 8'd1; build_wav(p);
    // empty data chunk with zero channels and rate
    p = plain_plan(); p.chans = '0; p.rate = '0; p.bits = rwhp_pkg::DEPTH_8;
    p.chunk_bytes = '0; p.payload_sent = '0; build_wav(p);
    // field maxima, long fmt chunk, chunks skipped on both sides of fmt
    p = plain_plan(); p.chans = '1; p.rate = '1; p.bits = rwhp_pkg::DEPTH_32;
    p.fmt_size = 32'd18;
    p.pre_junk = 2'd1; p.mid_junk = 2'd1; p.chunk_bytes = 32'd3; p.payload_sent = 8'd3;
    build_wav(p);
    // short fmt chunk still carries sixteen field bytes
    p = plain_plan(); p.fmt_size = 32'd4; p.bits = rwhp_pkg::DEPTH_24;
    p.chunk_bytes = 32'd1; p.payload_sent = 8'd1; build_wav(p);
    p = plain_plan(); p.riff_bad = 1'b1; build_wav(p);
    p = plain_plan(); p.wave_bad = 1'b1; build_wav(p);
    // not PCM wins over bad depth
    p = plain_plan(); p.fmt_code = 16'd3; p.bits = 16'd12; build_wav(p);
    p = plain_plan(); p.fmt_code = '1; build_wav(p);
    p = plain_plan(); p.bits = '1; build_wav(p);
    // stream ends on the last data header byte with a non-empty chunk
    p = plain_plan(); p.chunk_bytes = 32'd5; p.payload_sent = 8'd5; p.cut_len = 8'd44;
    build_wav(p);
    p = plain_plan(); p.no_fmt = 1'b1; p.pre_junk = 2'd1; build_wav(p);
    p = plain_plan(); p.cut_len = 8'd14; build_wav(p);
    p = plain_plan(); p.cut_len = 8'd18; build_wav(p);
    p = plain_plan(); p.cut_len = 8'd25; build_wav(p);
    p = plain_plan(); p.no_data = 1'b1; build_wav(p);
    // payload short of its declared size, then payload longer than declared
    p = plain_plan(); p.chunk_bytes = 32'd6; p.payload_sent = 8'd3; build_wav(p);
    p = plain_plan(); p.chunk_bytes = 32'd2; p.payload_sent = 8'd4; build_wav(p);
    directed_bytes = byte_stream.size();

    while (byte_stream.size() < directed_bytes + 150) begin
      if ($urandom_range(0, 14) == 0) build_noise();
      else build_wav(random_plan());
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (idx = 0; idx < byte_stream.size(); idx++) begin
      calm = (idx >= byte_stream.size() - 60);
      send_byte(byte_stream[idx][7:0], byte_stream[idx][8]);
    end
    in_tvalid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (20) @(posedge clk);

    $display("Streamed %0d bytes in %0d files under random gaps and back-pressure;",
             byte_stream.size(), file_count);
    $display("checked %0d format reports, %0d errors and %0d payload bytes.",
             reports_seen, errors_seen, payloads_seen);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
src/rwhp_pkg.sv
src/rwhp_in_reg.sv
src/rwhp_core.sv
src/rwhp_out_reg.sv
src/riff_wave_header_parser_unit.sv
verif/wav_result_checker.sv
verif/tb_riff_wave_header_parser_unit.sv
